/* rtl/via_pkg.sv */
// shared constants, codes and command/status types for the vibration alarm
// no dependencies; every other file of the block imports this package
`timescale 1ns / 1ps

package via_pkg;

    localparam int AXIS_W     = 16;
    localparam int SQ_W       = 32;
    localparam int MAG_W      = 16;
    localparam int SUM_W      = 23;
    localparam int AVG_W      = 17;
    localparam int HOLD_W     = 16;
    localparam int FLAGS_W    = 2;
    localparam int WINDOW_DEF = 50;

    localparam int MUL_STEPS  = 3;
    localparam int SQRT_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [FLAGS_W-1:0] FLAG_YELLOW = 2'b01;
    localparam logic [FLAGS_W-1:0] FLAG_RED    = 2'b10;

    localparam logic [1:0] REG_RED    = 2'd0;
    localparam logic [1:0] REG_YELLOW = 2'd1;
    localparam logic [1:0] REG_HOLD   = 2'd2;

    localparam logic [AVG_W-1:0]  RED_RST    = 17'd512;
    localparam logic [AVG_W-1:0]  YELLOW_RST = 17'd64;
    localparam logic [HOLD_W-1:0] HOLD_RST   = 16'd3000;

    typedef struct packed {
        logic       capture;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       sqrt_step;
        logic       acc;
        logic       div_step;
        logic       upd;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic win_close;
    } t_stat;

    typedef struct packed {
        logic [AVG_W-1:0]  red_level;
        logic [AVG_W-1:0]  yellow_level;
        logic [HOLD_W-1:0] hold_ticks;
    } t_cfg;

endpackage

/* rtl/vibration_intensity_alarm_unit.sv */
// top level of the vibration alarm: configuration registers on the APB
// port, sequencer and datapath; depends on via_pkg, via_ctrl and via_dp
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_ready) carries one three-axis sample per
// beat; the output channel (o_out_valid / i_out_ready) returns one result
// beat per sample: latched warning flags, latest window average and a flag
// that marks the sample that closed a window.
// After the accepting edge the result is built in these steps: three steps on
// the shared 16x16 squarer, sixteen steps of the two-bit-per-step square
// root, one accumulate, one update, one load. A sample that closes a window
// adds the reciprocal multiply by 1/WINDOW before the update.
// One item is at work at a time; a new sample is taken once the previous
// result sits in the output register, even while that result waits for the
// receiver.
// When the receiver stalls, the finished result holds in the output
// register and the next item, once computed, waits until the slot frees.
// Reset (synchronous, active low) clears the window sum, sample count, hold
// counter, flags and average, drops output valid and restores the register
// defaults: red 512, yellow 64, hold 3000 samples.
// Registers: red_level at 0x0, yellow_level at 0x4, hold_ticks at 0x8.

module vibration_intensity_alarm_unit #(
    parameter int WINDOW = via_pkg::WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [via_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [via_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [via_pkg::AXIS_W-1:0]  i_accel_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [via_pkg::FLAGS_W-1:0]        o_warning_flags,
    output logic [via_pkg::AVG_W-1:0]          o_window_average,
    output logic                               o_window_done,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [via_pkg::ADDR_W-1:0]         paddr,
    input  logic [via_pkg::DATA_W-1:0]         pwdata,
    output logic [via_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import via_pkg::*;

    logic [AVG_W-1:0]  r_red_level;
    logic [AVG_W-1:0]  r_yellow_level;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic              wr_en;
    t_cfg              cfg;
    t_cmd              cmd;
    t_stat             stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_level    <= RED_RST;
            r_yellow_level <= YELLOW_RST;
            r_hold_ticks   <= HOLD_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_RED:    r_red_level    <= pwdata[AVG_W-1:0];
                REG_YELLOW: r_yellow_level <= pwdata[AVG_W-1:0];
                REG_HOLD:   r_hold_ticks   <= pwdata[HOLD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RED:    prdata = DATA_W'(r_red_level);
            REG_YELLOW: prdata = DATA_W'(r_yellow_level);
            REG_HOLD:   prdata = DATA_W'(r_hold_ticks);
            default:    prdata = '0;
        endcase
    end

    assign cfg.red_level    = r_red_level;
    assign cfg.yellow_level = r_yellow_level;
    assign cfg.hold_ticks   = r_hold_ticks;

    via_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    via_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_warning_flags  (o_warning_flags),
        .o_window_average (o_window_average),
        .o_window_done    (o_window_done)
    );

endmodule

/* rtl/via_ctrl.sv */
// sequencer for the vibration alarm: multiply, square root, accumulate,
// divide, update and output steps; depends on via_pkg
`timescale 1ns / 1ps

module via_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  via_pkg::t_stat i_stat,
    output via_pkg::t_cmd  o_cmd
);
    import via_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_cmd              cmd;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = r_cnt[1:0];
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_cnt   = '0;
                n_state = i_stat.win_close ? S_DIV : S_UPD;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MUL))
        else $error("accepted beat did not start the multiply steps");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_valid)
        else $error("result load did not raise output valid");

    a_short_item_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && !i_stat.win_close) |=> (r_state == S_UPD))
        else $error("item that closes no window entered the divider");

    a_div_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_UPD))
        else $error("divide step took more than one cycle");

endmodule

/* rtl/via_dp.sv */
// datapath of the vibration alarm: shared squarer, digit square root,
// window sum, reciprocal multiply by the window length, flags; uses via_pkg
`timescale 1ns / 1ps

module via_dp #(
    parameter int WINDOW = via_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [via_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [via_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [via_pkg::AXIS_W-1:0] i_accel_z,
    input  via_pkg::t_cfg                 i_cfg,
    input  via_pkg::t_cmd                 i_cmd,
    output via_pkg::t_stat                o_stat,
    output logic [via_pkg::FLAGS_W-1:0]   o_warning_flags,
    output logic [via_pkg::AVG_W-1:0]     o_window_average,
    output logic                          o_window_done
);
    import via_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_C = CNT_W'(WINDOW);
    // exact floor division for any sum below 2^SUM_W
    localparam int DIV_SH = SUM_W + $clog2(WINDOW);
    localparam logic [SUM_W:0] RECIP =
        (SUM_W + 1)'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
        abs_axis = v[AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    // per-item working registers
    logic [AXIS_W-1:0] r_ax, r_ay, r_az;
    logic [SQ_W-1:0]   r_sq;
    logic [MAG_W:0]    r_rem;
    logic [MAG_W-1:0]  r_root;
    logic [SUM_W-1:0]  r_dnum;
    logic              r_done;

    // block state
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic [FLAGS_W-1:0] r_flags, n_flags;
    logic [AVG_W-1:0]   r_avg, n_avg;

    // output register
    logic [FLAGS_W-1:0] r_o_flags;
    logic [AVG_W-1:0]   r_o_avg;
    logic               r_o_done;

    logic [AXIS_W-1:0]  mul_op;
    logic [SQ_W-1:0]    prod;
    logic [MAG_W+2:0]   sq_trial_rem, sq_trial;
    logic               sq_ge;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [2*SUM_W:0]   dv_prod;
    logic [SUM_W-1:0]   dv_quo;

    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    mul_op = r_ax;
            2'd1:    mul_op = r_ay;
            default: mul_op = r_az;
        endcase
    end

    assign prod = mul_op * mul_op;

    // two radicand bits per step
    assign sq_trial_rem = {r_rem, r_sq[SQ_W-1 -: 2]};
    assign sq_trial     = {1'b0, r_root, 2'b01};
    assign sq_ge        = (sq_trial_rem >= sq_trial);

    assign sum_next         = r_sum + SUM_W'(r_root);
    assign cnt_next         = r_cnt + 1'b1;
    assign o_stat.win_close = (cnt_next >= WIN_C);

    assign dv_prod = r_dnum * RECIP;
    assign dv_quo  = SUM_W'(dv_prod >> DIV_SH);

    always_comb begin
        n_flags = r_flags;
        n_hold  = r_hold;
        n_avg   = r_avg;
        if (r_done) begin
            n_avg = r_dnum[AVG_W-1:0];
            if (n_avg >= i_cfg.red_level) begin
                n_flags = n_flags | FLAG_RED;
                n_hold  = i_cfg.hold_ticks;
            end else if (n_avg >= i_cfg.yellow_level) begin
                n_flags = n_flags | FLAG_YELLOW;
                n_hold  = i_cfg.hold_ticks;
            end
        end
        if (n_hold != '0) begin
            n_hold = n_hold - 1'b1;
        end else begin
            n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ax   <= abs_axis(i_accel_x);
            r_ay   <= abs_axis(i_accel_y);
            r_az   <= abs_axis(i_accel_z);
            r_sq   <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.mul_step) begin
            r_sq <= r_sq + prod;
        end
        if (i_cmd.sqrt_step) begin
            r_sq   <= {r_sq[SQ_W-3:0], 2'b00};
            r_rem  <= sq_ge ? (MAG_W + 1)'(sq_trial_rem - sq_trial)
                            : sq_trial_rem[MAG_W:0];
            r_root <= {r_root[MAG_W-2:0], sq_ge};
        end
        if (i_cmd.acc) begin
            r_dnum <= sum_next;
        end
        if (i_cmd.div_step) begin
            r_dnum <= dv_quo;
        end
        if (i_cmd.load_out) begin
            r_o_flags <= r_flags;
            r_o_avg   <= r_avg;
            r_o_done  <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_hold  <= '0;
            r_flags <= '0;
            r_avg   <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (o_stat.win_close) begin
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_sum  <= sum_next;
                    r_cnt  <= cnt_next;
                    r_done <= 1'b0;
                end
            end
            if (i_cmd.upd) begin
                r_flags <= n_flags;
                r_hold  <= n_hold;
                r_avg   <= n_avg;
            end
        end
    end

    assign o_warning_flags  = r_o_flags;
    assign o_window_average = r_o_avg;
    assign o_window_done    = r_o_done;

endmodule
